/* rtl/ibat_pkg.sv */
`default_nettype none

package ibat_pkg;

   // Item modes carried on req_tuser.
   localparam logic [1:0] MODE_BIND  = 2'd0;
   localparam logic [1:0] MODE_EVENT = 2'd1;
   localparam logic [1:0] MODE_POLL  = 2'd2;

   // Result status codes carried on rsp_tuser.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD_AXIS = 2'd3;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 104;
   localparam int TUSER_W     = 2;
   localparam int AXIS_SEL_W  = 4;

   // Search token that walks the binding chain one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic                  match;
      logic                  free_found;
      logic [AXIS_SEL_W-1:0] target;
   } ibat_token_type;

   // Command broadcast from the sequencer to every binding cell.
   typedef struct packed {
      logic                  start;
      logic                  commit_match;
      logic                  commit_free;
      logic [31:0]           key;
      logic [AXIS_SEL_W-1:0] target;
   } ibat_bind_cmd_type;

   // Stored stamps of one axis.
   typedef struct packed {
      logic [31:0] payload;
      logic [31:0] release_stamp;
      logic [31:0] press_stamp;
   } ibat_stamp_type;

   // Full visible state of one axis, in result field order from the top bit down.
   typedef struct packed {
      logic [31:0] payload;
      logic [31:0] release_stamp;
      logic [31:0] press_stamp;
      logic        held;
      logic        went_up;
      logic        went_down;
   } ibat_axis_rec_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SEARCH  = 4'b0010,
      ST_FETCH   = 4'b0100,
      ST_RESPOND = 4'b1000
   } ibat_state_type;

endpackage

`default_nettype wire

/* rtl/input_binding_axis_tracker_unit.sv */
`default_nettype none

// Channel   | Direction | tuser           | tdata fields (lowest bit up)
// ----------+-----------+-----------------+---------------------------------------------
// req_      | in        | mode [1:0]      | axis_select, event_code, source_kind,
//           |           |                 | pressed, event_time, event_value, zero pad
// rsp_      | out       | status [1:0]    | axis_index, went_down, went_up, held,
//           |           |                 | pressed_time, released_time, axis_value, pad
//
// One transaction is handled at a time. A bind or a matched event reaches the result register
// after the search token has walked the chain of binding cells one cell per cycle and the
// registered axis memory read has returned. An unmatched event skips the memory read; a new
// poll, an unused mode or a rejected bind goes straight to the result. Reset is synchronous
// and clears all bindings and all axis state.
// A stalled result holds in the output register; the next request is taken meanwhile.

module input_binding_axis_tracker_unit #(
   parameter int AXIS_COUNT = 16,
   parameter int BIND_DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // axis_select[3:0], event_code[19:4], source_kind[35:20], pressed[36],
   // event_time[68:37], event_value[100:69], zero[103:101]
   input  wire logic [ibat_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode[1:0]
   input  wire logic [ibat_pkg::TUSER_W-1:0]      req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // axis_index[3:0], went_down[4], went_up[5], held[6], pressed_time[38:7],
   // released_time[70:39], axis_value[102:71], zero[103]
   output logic [ibat_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // status[1:0]
   output logic [ibat_pkg::TUSER_W-1:0]           rsp_tuser
);

   localparam int AXW = $clog2(AXIS_COUNT);
   localparam logic [8:0] AXIS_LIMIT = 9'(AXIS_COUNT);
   localparam int SW = ibat_pkg::AXIS_SEL_W;

   ibat_pkg::ibat_state_type state_ff, state_in;

   // Captured request transaction.
   logic [1:0]    mode_ff;
   logic [SW-1:0] sel_ff;
   logic [31:0]   key_ff;
   logic          pressed_ff;
   logic [31:0]   time_ff;
   logic [31:0]   value_ff;

   logic          launch_ff, launch_in;
   logic [1:0]    status_ff, status_in;
   logic [SW-1:0] ax_ff, ax_in;
   logic          use_axis_ff, use_axis_in;

   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [ibat_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [ibat_pkg::TUSER_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   logic                       accept;
   logic                       rsp_free;
   logic                       sel_ok;
   logic                       poll_clear;
   logic                       store_wr;
   logic [SW+AXW-1:0]          ax_ext;
   logic [AXW-1:0]             ax_idx;
   ibat_pkg::ibat_axis_rec_type rd_rec;
   ibat_pkg::ibat_axis_rec_type upd_rec;
   ibat_pkg::ibat_axis_rec_type out_rec;
   ibat_pkg::ibat_bind_cmd_type cmd;
   ibat_pkg::ibat_token_type    tok [0:BIND_DEPTH];

   assign req_tready = (state_ff == ibat_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign sel_ok     = {5'd0, req_tdata[3:0]} < AXIS_LIMIT;
   assign poll_clear = accept && (req_tuser == ibat_pkg::MODE_POLL);

   // Axis numbers are 4 bits wide; widen before taking the memory index so that
   // any axis count works.
   assign ax_ext = {{AXW{1'b0}}, ax_ff};
   assign ax_idx = ax_ext[AXW-1:0];

   // The token enters the first cell the cycle after acceptance, once the key is
   // registered; the same cycle clears the cells' marks from the last search.
   assign tok[0] = '{valid: launch_ff, match: 1'b0, free_found: 1'b0, target: '0};

   for (genvar i = 0; i < BIND_DEPTH; i++) begin : g_cell
      ibat_bind_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   ibat_axis_store #(.AXIS_COUNT(AXIS_COUNT)) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (ax_idx),
      .rd_rec     (rd_rec),
      .wr_en      (store_wr),
      .wr_addr    (ax_idx),
      .wr_rec     (upd_rec),
      .poll_clear (poll_clear)
   );

   // Event update of the axis that was read: a press only latches the press
   // stamp when the axis was not already held, a release always does.
   always_comb begin
      upd_rec         = rd_rec;
      upd_rec.payload = value_ff;
      if (pressed_ff) begin
         if (!rd_rec.held) begin
            upd_rec.went_down   = 1'b1;
            upd_rec.held        = 1'b1;
            upd_rec.press_stamp = time_ff;
         end
      end else begin
         upd_rec.went_up       = 1'b1;
         upd_rec.held          = 1'b0;
         upd_rec.release_stamp = time_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      launch_in     = 1'b0;
      status_in     = status_ff;
      ax_in         = ax_ff;
      use_axis_in   = use_axis_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      store_wr      = 1'b0;
      out_rec       = '0;
      cmd.start        = launch_ff;
      cmd.commit_match = 1'b0;
      cmd.commit_free  = 1'b0;
      cmd.key          = key_ff;
      cmd.target       = sel_ff;

      unique case (state_ff)
         ibat_pkg::ST_IDLE: begin
            if (accept) begin
               ax_in       = '0;
               status_in   = ibat_pkg::STATUS_OK;
               use_axis_in = 1'b0;
               state_in    = ibat_pkg::ST_RESPOND;
               if (req_tuser == ibat_pkg::MODE_BIND) begin
                  if (sel_ok) begin
                     launch_in = 1'b1;
                     state_in  = ibat_pkg::ST_SEARCH;
                  end else begin
                     status_in = ibat_pkg::STATUS_BAD_AXIS;
                     ax_in     = req_tdata[3:0];
                  end
               end else if (req_tuser == ibat_pkg::MODE_EVENT) begin
                  launch_in = 1'b1;
                  state_in  = ibat_pkg::ST_SEARCH;
               end
            end
         end

         ibat_pkg::ST_SEARCH: begin
            // The token has left the last cell: the whole table has been seen.
            if (tok[BIND_DEPTH].valid) begin
               if (mode_ff == ibat_pkg::MODE_BIND) begin
                  ax_in       = sel_ff;
                  use_axis_in = 1'b1;
                  state_in    = ibat_pkg::ST_FETCH;
                  if (tok[BIND_DEPTH].match) begin
                     cmd.commit_match = 1'b1;
                     status_in        = ibat_pkg::STATUS_OK;
                  end else if (tok[BIND_DEPTH].free_found) begin
                     cmd.commit_free = 1'b1;
                     status_in       = ibat_pkg::STATUS_OK;
                  end else begin
                     status_in = ibat_pkg::STATUS_FULL;
                  end
               end else if (tok[BIND_DEPTH].match) begin
                  ax_in       = tok[BIND_DEPTH].target;
                  status_in   = ibat_pkg::STATUS_OK;
                  use_axis_in = 1'b1;
                  state_in    = ibat_pkg::ST_FETCH;
               end else begin
                  ax_in       = '0;
                  status_in   = ibat_pkg::STATUS_NO_MATCH;
                  use_axis_in = 1'b0;
                  state_in    = ibat_pkg::ST_RESPOND;
               end
            end
         end

         ibat_pkg::ST_FETCH: begin
            // The axis address is stable now; its registered read lands next cycle.
            state_in = ibat_pkg::ST_RESPOND;
         end

         ibat_pkg::ST_RESPOND: begin
            if (rsp_free) begin
               if (use_axis_ff) begin
                  if (mode_ff == ibat_pkg::MODE_EVENT) begin
                     out_rec  = upd_rec;
                     store_wr = 1'b1;
                  end else begin
                     out_rec = rd_rec;
                  end
               end
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, out_rec, ax_ff};
               rsp_tuser_in  = status_ff;
               state_in      = ibat_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ibat_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibat_pkg::ST_IDLE;
         launch_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         status_ff     <= ibat_pkg::STATUS_OK;
         ax_ff         <= '0;
         use_axis_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         status_ff     <= status_in;
         ax_ff         <= ax_in;
         use_axis_ff   <= use_axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_tuser;
         sel_ff     <= req_tdata[3:0];
         key_ff     <= req_tdata[35:4];
         pressed_ff <= req_tdata[36];
         time_ff    <= req_tdata[68:37];
         value_ff   <= req_tdata[100:69];
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

/* rtl/ibat_bind_cell.sv */
`default_nettype none

module ibat_bind_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ibat_pkg::ibat_bind_cmd_type cmd,
   input  wire ibat_pkg::ibat_token_type   tok_in,
   output ibat_pkg::ibat_token_type        tok_out
);

   logic                      valid_ff;
   logic [31:0]               key_ff;
   logic [ibat_pkg::AXIS_SEL_W-1:0] target_ff;
   logic                      match_mark_ff;
   logic                      free_mark_ff;
   ibat_pkg::ibat_token_type  tok_ff;
   ibat_pkg::ibat_token_type  tok_in_next;
   logic                      hit;
   logic                      free_here;

   // The first valid entry with the key claims the token; the first empty entry
   // marks itself as the place for a new binding.
   always_comb begin
      hit         = tok_in.valid && !tok_in.match && valid_ff && (key_ff == cmd.key);
      free_here   = tok_in.valid && !tok_in.free_found && !valid_ff;
      tok_in_next = tok_in;
      tok_in_next.match      = tok_in.match | hit;
      tok_in_next.free_found = tok_in.free_found | free_here;
      if (hit) begin
         tok_in_next.target = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         match_mark_ff <= 1'b0;
         free_mark_ff  <= 1'b0;
         tok_ff        <= '0;
      end else begin
         tok_ff <= tok_in_next;
         if (cmd.start) begin
            match_mark_ff <= 1'b0;
            free_mark_ff  <= 1'b0;
         end
         if (hit) begin
            match_mark_ff <= 1'b1;
         end
         if (free_here) begin
            free_mark_ff <= 1'b1;
         end
         if (cmd.commit_free && free_mark_ff) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.commit_match && match_mark_ff) || (cmd.commit_free && free_mark_ff)) begin
         target_ff <= cmd.target;
      end
      if (cmd.commit_free && free_mark_ff) begin
         key_ff <= cmd.key;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* rtl/ibat_axis_store.sv */
`default_nettype none

module ibat_axis_store #(
   parameter  int AXIS_COUNT = 16,
   localparam int AXW        = $clog2(AXIS_COUNT)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [AXW-1:0]              rd_addr,
   output ibat_pkg::ibat_axis_rec_type      rd_rec,
   input  wire logic                        wr_en,
   input  wire logic [AXW-1:0]              wr_addr,
   input  wire ibat_pkg::ibat_axis_rec_type wr_rec,
   input  wire logic                        poll_clear
);

   ibat_pkg::ibat_stamp_type mem_ff [AXIS_COUNT];
   ibat_pkg::ibat_stamp_type rd_stamp_ff;
   logic [AXIS_COUNT-1:0]    written_ff;
   logic [AXIS_COUNT-1:0]    held_ff;
   logic [AXIS_COUNT-1:0]    went_down_ff;
   logic [AXIS_COUNT-1:0]    went_up_ff;
   logic                     rd_written_ff;
   logic                     rd_held_ff;
   logic                     rd_went_down_ff;
   logic                     rd_went_up_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= '{payload:       wr_rec.payload,
                              release_stamp: wr_rec.release_stamp,
                              press_stamp:   wr_rec.press_stamp};
      end
      rd_stamp_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff      <= '0;
         held_ff         <= '0;
         went_down_ff    <= '0;
         went_up_ff      <= '0;
         rd_written_ff   <= 1'b0;
         rd_held_ff      <= 1'b0;
         rd_went_down_ff <= 1'b0;
         rd_went_up_ff   <= 1'b0;
      end else begin
         if (poll_clear) begin
            went_down_ff <= '0;
            went_up_ff   <= '0;
         end
         if (wr_en) begin
            written_ff[wr_addr]   <= 1'b1;
            held_ff[wr_addr]      <= wr_rec.held;
            went_down_ff[wr_addr] <= wr_rec.went_down;
            went_up_ff[wr_addr]   <= wr_rec.went_up;
         end
         rd_written_ff   <= written_ff[rd_addr];
         rd_held_ff      <= held_ff[rd_addr];
         rd_went_down_ff <= went_down_ff[rd_addr];
         rd_went_up_ff   <= went_up_ff[rd_addr];
      end
   end

   // An axis never written since reset reads as all zero stamps.
   always_comb begin
      rd_rec.went_down     = rd_went_down_ff;
      rd_rec.went_up       = rd_went_up_ff;
      rd_rec.held          = rd_held_ff;
      rd_rec.press_stamp   = rd_written_ff ? rd_stamp_ff.press_stamp : 32'd0;
      rd_rec.release_stamp = rd_written_ff ? rd_stamp_ff.release_stamp : 32'd0;
      rd_rec.payload       = rd_written_ff ? rd_stamp_ff.payload : 32'd0;
   end

endmodule

`default_nettype wire

/* rtl/ibat_port_checker.sv */
`default_nettype none

module ibat_port_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ibat_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [ibat_pkg::TUSER_W-1:0]      rsp_tuser
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only one request transaction is in flight, so none follows back to back.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken in consecutive cycles");

   // An unmatched event reports no axis and no state.
   a_no_match_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ibat_pkg::STATUS_NO_MATCH) |-> (rsp_tdata == '0))
      else $error("unmatched event carries axis state");

   // A rejected bind echoes the axis number and nothing else.
   a_bad_axis_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ibat_pkg::STATUS_BAD_AXIS)
      |-> (rsp_tdata[ibat_pkg::RSP_TDATA_W-1:4] == '0))
      else $error("rejected bind carries axis state");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind input_binding_axis_tracker_unit ibat_port_checker u_port_checker (.*);

`default_nettype wire

/* tb/sv/axis_tracker_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the input binding axis tracker, predicts the
// response of every request transaction and compares responses in order.
module axis_tracker_checker #(
   parameter int AXIS_COUNT = 16,
   parameter int BIND_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           awaiting,
   output int           mismatches
);

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  axis_index;
      logic        went_down;
      logic        went_up;
      logic        held;
      logic [31:0] press_t;
      logic [31:0] release_t;
      logic [31:0] value;
   } axis_report_type;

   // Binding table and per-axis state as the block should hold them.
   logic [31:0] bind_key  [BIND_DEPTH];
   logic        bind_used [BIND_DEPTH];
   logic [3:0]  bind_axis [BIND_DEPTH];
   logic        held_flag [AXIS_COUNT];
   logic        down_flag [AXIS_COUNT];
   logic        up_flag   [AXIS_COUNT];
   logic [31:0] press_reg [AXIS_COUNT];
   logic [31:0] release_reg [AXIS_COUNT];
   logic [31:0] payload_reg [AXIS_COUNT];

   axis_report_type expected_reports[$];
   int              fail_total = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_total++;
      $display("mismatch %0d at %0t: %s got %h want %h", fail_total, $time, what, got, want);
   endtask

   function automatic int lookup_binding(input logic [31:0] key);
      for (int i = 0; i < BIND_DEPTH; i++) begin
         if (bind_used[i] && bind_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic axis_report_type snapshot_axis(input logic [1:0] status,
                                                     input logic [3:0] ax);
      axis_report_type r;
      r.status     = status;
      r.axis_index = ax;
      r.went_down  = down_flag[ax];
      r.went_up    = up_flag[ax];
      r.held       = held_flag[ax];
      r.press_t    = press_reg[ax];
      r.release_t  = release_reg[ax];
      r.value      = payload_reg[ax];
      return r;
   endfunction

   // Applies one request to the model state and returns the response it should give.
   function automatic axis_report_type predict_axis_report(input logic [1:0] mode,
                                                           input logic [103:0] data);
      axis_report_type r;
      logic [3:0]      sel;
      logic [31:0]     key;
      logic            down;
      logic [31:0]     when;
      logic [31:0]     payload;
      logic [3:0]      ax;
      int              slot;
      r       = '0;
      sel     = data[3:0];
      key     = data[35:4];
      down    = data[36];
      when    = data[68:37];
      payload = data[100:69];
      case (mode)
         ibat_pkg::MODE_BIND: begin
            if (int'(sel) >= AXIS_COUNT) begin
               // Axis beyond the configured count: nothing stored, axis number echoed.
               r.status     = ibat_pkg::STATUS_BAD_AXIS;
               r.axis_index = sel;
            end else begin
               slot = lookup_binding(key);
               if (slot < 0) begin
                  for (int i = BIND_DEPTH - 1; i >= 0; i--) begin
                     if (!bind_used[i]) slot = i;
                  end
               end
               if (slot < 0) begin
                  r = snapshot_axis(ibat_pkg::STATUS_FULL, sel);
               end else begin
                  bind_used[slot] = 1'b1;
                  bind_key[slot]  = key;
                  bind_axis[slot] = sel;
                  r = snapshot_axis(ibat_pkg::STATUS_OK, sel);
               end
            end
         end
         ibat_pkg::MODE_EVENT: begin
            slot = lookup_binding(key);
            if (slot < 0) begin
               r.status = ibat_pkg::STATUS_NO_MATCH;
            end else begin
               ax = bind_axis[slot];
               if (down) begin
                  // A repeated press while held only refreshes the payload.
                  if (!held_flag[ax]) begin
                     down_flag[ax] = 1'b1;
                     held_flag[ax] = 1'b1;
                     press_reg[ax] = when;
                  end
               end else begin
                  up_flag[ax]     = 1'b1;
                  held_flag[ax]   = 1'b0;
                  release_reg[ax] = when;
               end
               payload_reg[ax] = payload;
               r = snapshot_axis(ibat_pkg::STATUS_OK, ax);
            end
         end
         ibat_pkg::MODE_POLL: begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
               down_flag[i] = 1'b0;
               up_flag[i]   = 1'b0;
            end
            r.status = ibat_pkg::STATUS_OK;
         end
         default: begin
            r.status = ibat_pkg::STATUS_OK;
         end
      endcase
      return r;
   endfunction

   task automatic check_response();
      axis_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("response with none expected, axis_index",
                         32'(rsp_tdata[3:0]), '0);
      end else begin
         want = expected_reports.pop_front();
         if (rsp_tuser !== want.status)
            report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         if (rsp_tdata[3:0] !== want.axis_index)
            report_mismatch("axis_index", 32'(rsp_tdata[3:0]), 32'(want.axis_index));
         if (rsp_tdata[4] !== want.went_down)
            report_mismatch("went_down", 32'(rsp_tdata[4]), 32'(want.went_down));
         if (rsp_tdata[5] !== want.went_up)
            report_mismatch("went_up", 32'(rsp_tdata[5]), 32'(want.went_up));
         if (rsp_tdata[6] !== want.held)
            report_mismatch("held", 32'(rsp_tdata[6]), 32'(want.held));
         if (rsp_tdata[38:7] !== want.press_t)
            report_mismatch("pressed_time", rsp_tdata[38:7], want.press_t);
         if (rsp_tdata[70:39] !== want.release_t)
            report_mismatch("released_time", rsp_tdata[70:39], want.release_t);
         if (rsp_tdata[102:71] !== want.value)
            report_mismatch("axis_value", rsp_tdata[102:71], want.value);
         if (rsp_tdata[103] !== 1'b0)
            report_mismatch("pad bit", 32'(rsp_tdata[103]), '0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BIND_DEPTH; i++) bind_used[i] = 1'b0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            held_flag[i]   = 1'b0;
            down_flag[i]   = 1'b0;
            up_flag[i]     = 1'b0;
            press_reg[i]   = '0;
            release_reg[i] = '0;
            payload_reg[i] = '0;
         end
         expected_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready)
            expected_reports.push_back(predict_axis_report(req_tuser, req_tdata));
      end
      awaiting   <= expected_reports.size();
      mismatches <= fail_total;
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Top level of the input binding axis tracker test. This module only makes
// request transactions, throttles the response side and gives the verdict;
// prediction and comparison live in the checker instantiated beside the block.
module tb;

   localparam int AXIS_COUNT   = 16;
   localparam int BIND_DEPTH   = 32;
   localparam int RANDOM_ITEMS = 850;
   // The tail wait after the last response is longer than the processing of one
   // bind or event, with some margin.
   localparam int DRAIN_CYCLES = BIND_DEPTH + 16;
   // Longest correct quiet stretch is roughly one item of processing, one long
   // response stall and one sender gap; the limit is many times that.
   localparam int IDLE_LIMIT   = 4000;
   // The fourth mode value has no meaning and must be ignored by the block.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_style_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // axis_select[3:0], event_code[19:4], source_kind[35:20], pressed[36],
   // event_time[68:37], event_value[100:69], zero[103:101]
   logic [103:0] req_tdata;
   // mode[1:0]
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // axis_index[3:0], went_down[4], went_up[5], held[6], pressed_time[38:7],
   // released_time[70:39], axis_value[102:71], zero[103]
   logic [103:0] rsp_tdata;
   // status[1:0]
   logic [1:0]   rsp_tuser;

   int awaiting;
   int mismatches;

   // Keys the stimulus has tried to bind. The list is capped a little above
   // the table depth so that most events hit a live binding even after the
   // table has filled up.
   logic [31:0] known_keys[$];
   int unsigned burst_left = 0;

   input_binding_axis_tracker_unit #(
      .AXIS_COUNT(AXIS_COUNT),
      .BIND_DEPTH(BIND_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   axis_tracker_checker #(
      .AXIS_COUNT(AXIS_COUNT),
      .BIND_DEPTH(BIND_DEPTH)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .awaiting  (awaiting),
      .mismatches(mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Builds the request payload. The key's low half is the event code and its
   // high half the source kind, so the key drops straight into bits 35:4.
   function automatic logic [103:0] pack_request(input logic [3:0] sel,
                                                 input logic [31:0] key,
                                                 input logic pressed,
                                                 input logic [31:0] when,
                                                 input logic [31:0] value);
      return {3'b000, value, when, pressed, key[31:16], key[15:0], sel};
   endfunction

   function automatic logic [31:0] pick_known_key();
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
   endfunction

   // A key one bit away from a known one: it lands next to a live binding
   // without matching it, either in the code or in the source kind half.
   function automatic logic [31:0] near_miss_key();
      return pick_known_key() ^ (32'h1 << $urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] random_stamp();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Presents one request transaction from a falling edge and returns at the
   // falling edge after it was taken. The sender runs in bursts: inside a
   // burst tvalid stays high from one transaction to the next, and between
   // bursts it drops for a random gap, sometimes of zero length.
   task automatic send_item(input logic [1:0] mode, input logic [103:0] data);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Response side throttling: it switches between several stall styles, each
   // kept for a random span, including long stretches where it never stalls.
   initial begin
      ready_style_type style;
      int unsigned     span;
      rsp_tready = 1'b0;
      style = READY_ALWAYS;
      span  = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            style = ready_style_type'($urandom_range(0, 3));
            span  = $urandom_range(20, 400);
         end
         span--;
         case (style)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_COIN:    rsp_tready <= 1'($urandom);
            READY_SPARSE:  rsp_tready <= ($urandom_range(0, 15) == 0);
            default:       rsp_tready <= ((span % 9) < 3);
         endcase
      end
   end

   // Watchdog: ends the run when no transaction moves on either side for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      logic [31:0] key;
      int unsigned pick;
      int unsigned roll;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ibat_pkg::MODE_BIND;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Events before any bind find no match, then a handful of
      // bindings at the key extremes are driven through press, repeated press,
      // release while not held, a new poll and a rebind of a live key.
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'h0000_0000, 1'b1, 32'h1, 32'h2));
      send_item(ibat_pkg::MODE_POLL, pack_request(4'h0, 32'h0000_0000, 1'b0, '0, '0));
      send_item(MODE_UNUSED, {3'b000, {101{1'b1}}});
      send_item(ibat_pkg::MODE_BIND, pack_request(4'h0, 32'h0000_0000, 1'b0, '0, '0));
      send_item(ibat_pkg::MODE_BIND, pack_request(4'hF, 32'hFFFF_FFFF, 1'b1, '1, '1));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'h0000_0000, 1'b1, 32'h0, 32'h0));
      // Second press while held: only the payload may change.
      send_item(ibat_pkg::MODE_EVENT, pack_request(4'hF, 32'h0000_0000, 1'b1, '1, '1));
      // Release of an axis that was never pressed still stamps the release.
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'hFFFF_FFFF, 1'b0, '1, 32'hA5A5_A5A5));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'hFFFF_FFFF, 1'b1, 32'h1, 32'h5A5A_5A5A));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'h0000_0000, 1'b0, 32'h8000_0000, 32'h1));
      send_item(ibat_pkg::MODE_POLL, pack_request(4'hF, 32'hFFFF_FFFF, 1'b1, '1, '1));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFF, '0));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'h0000_0000, 1'b1, 32'h0000_0010, '1));
      // Rebind a live key so that two keys now drive the same axis.
      send_item(ibat_pkg::MODE_BIND, pack_request(4'hF, 32'h0000_0000, 1'b0, '0, '0));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'h0, 32'h0000_0000, 1'b0, 32'h0000_0020, 32'h3));
      // Keys that share one half with a live binding must not match.
      send_item(ibat_pkg::MODE_EVENT, pack_request(4'h0, 32'h0000_FFFF, 1'b1, '1, '1));
      send_item(ibat_pkg::MODE_EVENT, pack_request(4'h0, 32'hFFFF_0000, 1'b1, '1, '1));
      send_item(ibat_pkg::MODE_BIND, pack_request(4'h5, 32'hFFFF_0000, 1'b1, '1, '1));
      send_item(ibat_pkg::MODE_EVENT,
                pack_request(4'hA, 32'hFFFF_0000, 1'b1, 32'h0000_0030, '0));
      send_item(MODE_UNUSED, pack_request(4'h0, 32'h0000_0000, 1'b0, '0, '0));
      known_keys.push_back(32'h0000_0000);
      known_keys.push_back(32'hFFFF_FFFF);
      known_keys.push_back(32'hFFFF_0000);

      // Random part. Binds add fresh keys until the table is full, after which
      // new keys are refused while rebinds of live keys still succeed. Events
      // mostly use known keys with random press state and stamps, so the axes
      // cycle through press, hold and release; polls clear the edge flags.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         roll = $urandom_range(0, 19);
         if (pick < 18) begin
            if (roll < 12)      key = $urandom;
            else if (roll < 17) key = pick_known_key();
            else                key = near_miss_key();
            if (known_keys.size() < BIND_DEPTH + 8) known_keys.push_back(key);
            send_item(ibat_pkg::MODE_BIND, pack_request(4'($urandom), key, 1'($urandom),
                                                        $urandom, $urandom));
         end else if (pick < 80) begin
            if (roll < 17)      key = pick_known_key();
            else if (roll < 19) key = near_miss_key();
            else                key = $urandom;
            send_item(ibat_pkg::MODE_EVENT, pack_request(4'($urandom), key, 1'($urandom),
                                                         random_stamp(), random_stamp()));
         end else if (pick < 96) begin
            send_item(ibat_pkg::MODE_POLL, pack_request(4'($urandom), $urandom,
                                                        1'($urandom), $urandom, $urandom));
         end else begin
            send_item(MODE_UNUSED, pack_request(4'($urandom), $urandom, 1'($urandom),
                                                $urandom, $urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Wait for every predicted response, then a little longer so that any
      // spurious extra response would still be caught.
      while (awaiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
